### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the sort engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ese_pkg.sv
// ----------------------------------------------------------------------------
// ese_pkg
// Types, sizes and sequencer states of the exchange sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ese_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    typedef struct packed {
        logic  en;
        idx_t  addr;
        word_t data;
    } mem_wr_t;

    typedef struct packed {
        logic en;
        idx_t addr;
    } mem_rd_t;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_SFETCH,
        S_FIRST,
        S_SCAN,
        S_STORE,
        S_EFETCH,
        S_EWAIT
    } state_t;

endpackage

### rtl/ese_mem.sv
// ----------------------------------------------------------------------------
// ese_mem
// Element buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ese_mem (
    input  logic            aclk,
    input  ese_pkg::mem_wr_t wr,
    input  ese_pkg::mem_rd_t rd,
    output ese_pkg::word_t  rd_data
);
    import ese_pkg::*;

    word_t mem [DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/ese_cmpswap.sv
// ----------------------------------------------------------------------------
// ese_cmpswap
// Shared signed compare-exchange unit: orders two words into low and high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ese_cmpswap (
    input  ese_pkg::word_t a,
    input  ese_pkg::word_t b,
    output ese_pkg::word_t lo,
    output ese_pkg::word_t hi
);
    import ese_pkg::*;

    logic swap;

    // equal values never swap
    assign swap = (a > b);
    assign lo   = swap ? b : a;
    assign hi   = swap ? a : b;

endmodule

### rtl/exchange_sort_engine.sv
// ----------------------------------------------------------------------------
// exchange_sort_engine
// Buffers a set of signed words, exchange-sorts them ascending, streams them out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready, s_value, s_last): one word per transfer,
//   s_last on the final word of a set. Words beyond DEPTH are dropped and every
//   result of that set carries m_overflow.
//   Result channel (m_valid/m_ready, m_sorted_value, m_last_out, m_overflow):
//   the stored words in ascending signed order, m_last_out on the final one.
//   Collection accepts one word per cycle. After the final word the single
//   compare-exchange unit sorts over the one read and one write port: each pass
//   compares its running minimum with each later word and writes the larger
//   back, then stores the minimum at its head; n*(n-1)/2 compares for n >= 2
//   words. Results then leave at one per cycle while m_ready is high; a stalled
//   receiver holds the current result and the sequencer waits. s_ready is low
//   from the final word until the last result transfers.
//   Reset (aresetn low, synchronous) empties the set and returns to collection;
//   buffer contents need no clearing since only words of the current set are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module exchange_sort_engine (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ese_pkg::word_t s_value,
    input  logic           s_last,
    output logic           m_valid,
    input  logic           m_ready,
    output ese_pkg::word_t m_sorted_value,
    output logic           m_last_out,
    output logic           m_overflow
);
    import ese_pkg::*;

    state_t  state_reg, state_next;
    cnt_t    count_reg, count_next;
    logic    dropped_reg, dropped_next;
    idx_t    p_reg, p_next;
    idx_t    q_reg, q_next;
    word_t   a_reg, a_next;

    mem_wr_t mem_wr;
    mem_rd_t mem_rd;
    word_t   rd_data;
    word_t   cmp_lo, cmp_hi;
    cnt_t    count_inc;
    logic    emit_last;

    ese_mem u_mem (
        .aclk    (aclk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (rd_data)
    );

    ese_cmpswap u_cmpswap (
        .a  (a_reg),
        .b  (rd_data),
        .lo (cmp_lo),
        .hi (cmp_hi)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_COLLECT;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            p_reg       <= '0;
            q_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            p_reg       <= p_next;
            q_reg       <= q_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
    end

    assign emit_last = ((CNT_W'(p_reg) + CNT_W'(1)) == count_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        a_next       = a_reg;
        mem_wr       = '0;
        mem_rd       = '0;
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        count_inc    = count_reg;

        unique case (state_reg)
            S_COLLECT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (count_reg < CNT_W'(DEPTH)) begin
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = count_reg[IDX_W-1:0];
                        mem_wr.data = s_value;
                        count_inc   = count_reg + CNT_W'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                    count_next = count_inc;
                    if (s_last) begin
                        p_next = '0;
                        if (count_inc >= CNT_W'(2)) begin
                            state_next = S_SFETCH;
                        end else begin
                            state_next = S_EFETCH;
                        end
                    end
                end
            end
            S_SFETCH: begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = p_reg;
                q_next      = p_reg + IDX_W'(1);
                state_next  = S_FIRST;
            end
            S_FIRST: begin
                // entry p becomes the running minimum of this pass
                a_next      = rd_data;
                mem_rd.en   = 1'b1;
                mem_rd.addr = q_reg;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = q_reg;
                mem_wr.data = cmp_hi;
                a_next      = cmp_lo;
                if ((CNT_W'(q_reg) + CNT_W'(1)) < count_reg) begin
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = q_reg + IDX_W'(1);
                    q_next      = q_reg + IDX_W'(1);
                end else begin
                    state_next = S_STORE;
                end
            end
            S_STORE: begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = p_reg;
                mem_wr.data = a_reg;
                if ((CNT_W'(p_reg) + CNT_W'(2)) < count_reg) begin
                    // fetch the next pass head alongside the write-back
                    mem_rd.en   = 1'b1;
                    mem_rd.addr = p_reg + IDX_W'(1);
                    q_next      = p_reg + IDX_W'(2);
                    p_next      = p_reg + IDX_W'(1);
                    state_next  = S_FIRST;
                end else begin
                    p_next     = '0;
                    state_next = S_EFETCH;
                end
            end
            S_EFETCH: begin
                mem_rd.en   = 1'b1;
                mem_rd.addr = p_reg;
                state_next  = S_EWAIT;
            end
            S_EWAIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (emit_last) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = S_COLLECT;
                    end else begin
                        mem_rd.en   = 1'b1;
                        mem_rd.addr = p_reg + IDX_W'(1);
                        p_next      = p_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_COLLECT;
            end
        endcase
    end

    assign m_sorted_value = rd_data;
    assign m_last_out     = emit_last;
    assign m_overflow     = dropped_reg;

    `ASSERT_ALWAYS(a_one_side, aclk, aresetn, !(s_ready && m_valid))
    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `ASSERT_IMPL(a_scan_order, aclk, aresetn, state_reg == S_SCAN, q_reg > p_reg)
    `ASSERT_NEXT(a_set_done, aclk, aresetn, m_valid && m_ready && m_last_out,
        count_reg == '0 && !dropped_reg && state_reg == S_COLLECT)

endmodule

### bench/exchange_sort_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exchange_sort_engine_tb
// Sends sets of signed words to the sort engine with random idle gaps on the
// input side and random stalls on the result side. Each set is sorted in the
// scoreboard as it ends. Every result is checked in order against that list.
// ----------------------------------------------------------------------------

module exchange_sort_engine_tb;
    import ese_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int WORD_BUDGET = 250;

    localparam word_t WORD_MAX = word_t'(32'h7FFF_FFFF);
    localparam word_t WORD_MIN = word_t'(32'h8000_0000);

    typedef struct {
        word_t value;
        logic  last;
        logic  overflow;
    } sorted_word_t;

    class sort_scoreboard;
        word_t        held[DEPTH];
        int           held_count;
        bit           dropped;
        sorted_word_t expected_order[$];
        int           mismatches;

        function new();
            held_count = 0;
            dropped    = 1'b0;
            mismatches = 0;
        endfunction

        // store one accepted word; on the final word sort the set and queue it
        function void take_element(word_t v, logic fin);
            int           p;
            int           q;
            word_t        swap_word;
            sorted_word_t r;
            if (held_count < DEPTH) begin
                held[held_count] = v;
                held_count++;
            end else begin
                dropped = 1'b1;
            end
            if (fin) begin
                for (p = 0; p < held_count; p++) begin
                    for (q = p + 1; q < held_count; q++) begin
                        // equal words stay where they are
                        if (held[p] > held[q]) begin
                            swap_word = held[p];
                            held[p]   = held[q];
                            held[q]   = swap_word;
                        end
                    end
                end
                for (p = 0; p < held_count; p++) begin
                    r.value    = held[p];
                    r.last     = (p == held_count - 1);
                    r.overflow = dropped;
                    expected_order.push_back(r);
                end
                held_count = 0;
                dropped    = 1'b0;
            end
        endfunction

        function void check_output(word_t v, logic l, logic o);
            sorted_word_t want;
            if (expected_order.size() == 0) begin
                $error("unexpected result: sorted_value %0d", v);
                mismatches++;
                return;
            end
            want = expected_order.pop_front();
            if (v !== want.value) begin
                $error("sorted_value: expected %0d, got %0d", want.value, v);
                mismatches++;
            end
            if (l !== want.last) begin
                $error("last_out: expected %0b, got %0b", want.last, l);
                mismatches++;
            end
            if (o !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, o);
                mismatches++;
            end
        endfunction
    endclass

    logic  aclk;
    logic  aresetn = 1'b0;
    logic  s_valid = 1'b0;
    logic  s_ready;
    word_t s_value = '0;
    logic  s_last  = 1'b0;
    logic  m_valid;
    logic  m_ready = 1'b0;
    word_t m_sorted_value;
    logic  m_last_out;
    logic  m_overflow;

    sort_scoreboard board = new();
    int words_sent  = 0;
    int idle_cycles = 0;

    exchange_sort_engine dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic word_t rand_word();
        int small_v;
        small_v = $urandom_range(0, 16);
        case ($urandom_range(0, 9))
            0: return WORD_MIN;
            1: return WORD_MAX;
            // narrow range so that sets hold repeated words
            2, 3: return word_t'(small_v - 8);
            default: return word_t'($urandom);
        endcase
    endfunction

    // valid stays high across back-to-back transfers, it only drops for a gap
    task automatic send_word(word_t v, logic fin, bit eager);
        int gap;
        gap = eager ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= fin;
        do @(posedge aclk); while (s_ready !== 1'b1);
        board.take_element(v, fin);
        words_sent++;
    endtask

    task automatic send_list(word_t vals[$], bit eager);
        int i;
        for (i = 0; i < vals.size(); i++) begin
            send_word(vals[i], i == vals.size() - 1, eager);
        end
    endtask

    task automatic send_random_set(int len, bit eager);
        int i;
        for (i = 0; i < len; i++) begin
            send_word(rand_word(), i == len - 1, eager);
        end
    endtask

    initial begin
        word_t set_q[$];
        int    set_idx;
        int    set_len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        set_q = '{WORD_MAX};
        send_list(set_q, 1'b0);
        set_q = '{WORD_MIN};
        send_list(set_q, 1'b1);
        set_q = '{WORD_MAX, WORD_MIN, word_t'(0), word_t'(-1), word_t'(1)};
        send_list(set_q, 1'b0);
        set_q = '{word_t'(7), word_t'(7), word_t'(-3), word_t'(7), word_t'(-3)};
        send_list(set_q, 1'b1);
        set_q = '{word_t'(5), word_t'(4), word_t'(3), word_t'(2), word_t'(1), word_t'(0),
                  word_t'(-1)};
        send_list(set_q, 1'b0);
        set_q = '{WORD_MIN, word_t'(-1), word_t'(0), WORD_MAX};
        send_list(set_q, 1'b0);

        // a full buffer early on, then a set whose tail (final word too) is dropped
        set_idx = 0;
        while (words_sent < WORD_BUDGET) begin
            if (set_idx == 2) begin
                set_len = DEPTH;
            end else if (set_idx == 5) begin
                set_len = DEPTH + 2;
            end else if ($urandom_range(0, 9) == 0) begin
                set_len = $urandom_range(13, 40);
            end else begin
                set_len = $urandom_range(1, 12);
            end
            send_random_set(set_len, $urandom_range(0, 3) == 0);
            set_idx++;
        end
        s_valid <= 1'b0;

        while (board.expected_order.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (board.mismatches == 0) begin
            $display("exchange_sort_engine_tb: PASS");
        end else begin
            $display("exchange_sort_engine_tb: FAIL");
        end
        $finish;
    end

    // result side: random stall before each transfer, with calm stretches
    initial begin
        int gap;
        int calm_left;
        calm_left = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (calm_left > 0) begin
                gap = 0;
                calm_left--;
            end else begin
                gap = $urandom_range(0, 18);
                if ($urandom_range(0, 15) == 0) calm_left = $urandom_range(5, 40);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            board.check_output(m_sorted_value, m_last_out, m_overflow);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("exchange_sort_engine_tb: FAIL");
                $finish;
            end
        end
    end

endmodule
